FILE: rtl/u8sc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sc_pkg: shared types and constants for the UTF-8 safe chunker
// Word layouts of both channels, the release descriptor and byte codes.
// ----------------------------------------------------------------------------
package u8sc_pkg;

    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 12;
    localparam int DLEN_W   = 7;    // holds lengths up to the largest hold depth
    localparam int IDX_W    = 8;    // holds the sum of two lengths
    localparam int DQ_DEPTH = 4;
    localparam int DQ_AW    = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd256;
    localparam logic [BYTE_W-1:0]  CONT_MASK   = 8'hC0;
    localparam logic [BYTE_W-1:0]  CONT_MARK   = 8'h80;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              msg_last;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              chunk_start;
        logic              message_end;
        logic              split_error;
        logic              run_last;
    } out_word_t;

    // Results of one input word: unit A bytes, then unit B bytes, then an
    // optional error result.
    typedef struct packed {
        logic [DLEN_W-1:0] a_len;
        logic              a_fresh;
        logic [DLEN_W-1:0] b_len;
        logic              b_fresh;
        logic              err;
        logic              msg_end;
    } desc_t;

endpackage

FILE: rtl/u8sc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module u8sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/u8sc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sc_step: input register and per-byte segmentation step
// Collects units in the byte queue, decides chunk starts and errors,
// and posts one release descriptor per word that yields results.
// ----------------------------------------------------------------------------
module u8sc_step #(
    parameter int HOLD_DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  u8sc_pkg::in_word_t                in_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [u8sc_pkg::LIMIT_W-1:0]      cfg_data,
    input  logic [$clog2(HOLD_DEPTH)+1:0]     rd_ptr,
    input  logic                              desc_full,
    output logic                              ram_we,
    output logic [$clog2(HOLD_DEPTH):0]       ram_waddr,
    output logic [u8sc_pkg::BYTE_W-1:0]       ram_wdata,
    output logic                              desc_push,
    output u8sc_pkg::desc_t                   desc
);
    import u8sc_pkg::*;

    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam int AW         = $clog2(HOLD_DEPTH) + 1;
    localparam int PW         = AW + 1;
    localparam int DATA_DEPTH = 1 << AW;
    localparam int SUM_W      = LIMIT_W + 1;

    logic              in_valid_reg, in_valid_next;
    in_word_t          in_word_reg;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [LIMIT_W-1:0] fill_reg, fill_next;
    logic              inmsg_reg, inmsg_next;
    logic              drop_reg, drop_next;
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [LIMIT_W-1:0] max_len_reg;

    logic              cont, last, room, step_go, accept;
    logic              err, stop, we;
    logic [CNT_W-1:0]  a_len, b_len, h1, h2;
    logic              a_fresh, b_fresh;
    logic [LIMIT_W-1:0] f1;
    logic [SUM_W-1:0]  max_ext, sum_a, sum_b;

    assign cont    = (in_word_reg.data_byte & CONT_MASK) == CONT_MARK;
    assign last    = in_word_reg.msg_last;
    assign room    = (wr_ptr_reg - rd_ptr) != PW'(DATA_DEPTH);
    assign step_go = in_valid_reg && room && !desc_full;
    assign in_stall = in_valid_reg && !step_go;
    assign accept  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign max_ext = SUM_W'(max_len_reg);
    assign sum_a   = SUM_W'(fill_reg) + SUM_W'(held_reg);
    assign sum_b   = SUM_W'(f1) + SUM_W'(h2);

    always_comb
    begin
        err     = 1'b0;
        stop    = 1'b0;
        we      = 1'b0;
        a_len   = '0;
        a_fresh = 1'b0;
        b_len   = '0;
        b_fresh = 1'b0;
        h1      = held_reg;
        h2      = held_reg + CNT_W'(1);
        f1      = fill_reg;
        if (drop_reg)
        begin
            err = last;
        end
        else
        begin
            // a lead byte completes the unit held so far
            if (inmsg_reg && !cont && (held_reg != '0))
            begin
                if (SUM_W'(held_reg) > max_ext)
                begin
                    err  = 1'b1;
                    stop = 1'b1;
                end
                else
                begin
                    a_len   = held_reg;
                    a_fresh = (fill_reg == '0) || (sum_a > max_ext);
                    f1      = a_fresh ? LIMIT_W'(held_reg) : sum_a[LIMIT_W-1:0];
                    h1      = '0;
                end
            end
            if (!stop && (h1 >= CNT_W'(HOLD_DEPTH)))
            begin
                err  = 1'b1;
                stop = 1'b1;
            end
            h2 = h1 + CNT_W'(1);
            if (!stop)
            begin
                we = 1'b1;
                if (last)
                begin
                    if (SUM_W'(h2) > max_ext)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        b_len   = h2;
                        b_fresh = (f1 == '0) || (sum_b > max_ext);
                    end
                end
            end
        end
    end

    always_comb
    begin
        held_next   = held_reg;
        fill_next   = fill_reg;
        inmsg_next  = inmsg_reg;
        drop_next   = drop_reg;
        wr_ptr_next = wr_ptr_reg;
        if (step_go)
        begin
            if (err)
            begin
                // held bytes were never released: roll the write side back
                wr_ptr_next = wr_ptr_reg - PW'(h1);
                held_next   = '0;
                fill_next   = '0;
                inmsg_next  = 1'b0;
                drop_next   = !last;
            end
            else if (drop_reg)
            begin
                drop_next = drop_reg;
            end
            else if (last)
            begin
                wr_ptr_next = wr_ptr_reg + PW'(1);
                held_next   = '0;
                fill_next   = '0;
                inmsg_next  = 1'b0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + PW'(1);
                held_next   = h2;
                fill_next   = f1;
                inmsg_next  = 1'b1;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_go)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            held_reg     <= '0;
            fill_reg     <= '0;
            inmsg_reg    <= 1'b0;
            drop_reg     <= 1'b0;
            wr_ptr_reg   <= '0;
            max_len_reg  <= LIMIT_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            held_reg     <= held_next;
            fill_reg     <= fill_next;
            inmsg_reg    <= inmsg_next;
            drop_reg     <= drop_next;
            wr_ptr_reg   <= wr_ptr_next;
            if (cfg_valid)
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= in_word;
        end
    end

    assign ram_we    = step_go && we;
    assign ram_waddr = wr_ptr_reg[AW-1:0];
    assign ram_wdata = in_word_reg.data_byte;

    assign desc_push    = step_go && (err || (a_len != '0) || (b_len != '0));
    assign desc.a_len   = DLEN_W'(a_len);
    assign desc.a_fresh = a_fresh;
    assign desc.b_len   = DLEN_W'(b_len);
    assign desc.b_fresh = b_fresh;
    assign desc.err     = err;
    assign desc.msg_end = last;

endmodule

FILE: rtl/u8sc_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sc_emit: result sequencer
// Walks release descriptors, reads released bytes from the byte queue and
// drives the output register, one result per cycle while out_stall does not hold it.
// ----------------------------------------------------------------------------
module u8sc_emit #(
    parameter int HOLD_DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              desc_push,
    input  u8sc_pkg::desc_t                   desc,
    output logic                              desc_full,
    output logic [$clog2(HOLD_DEPTH)+1:0]     rd_ptr,
    output logic                              ram_re,
    output logic [$clog2(HOLD_DEPTH):0]       ram_raddr,
    input  logic [u8sc_pkg::BYTE_W-1:0]       ram_rdata,
    output logic                              out_valid,
    input  logic                              out_stall,
    output u8sc_pkg::out_word_t               out_word
);
    import u8sc_pkg::*;

    localparam int AW = $clog2(HOLD_DEPTH) + 1;
    localparam int PW = AW + 1;

    desc_t             dq_mem_reg [DQ_DEPTH];
    logic [DQ_AW:0]    dq_wr_reg, dq_rd_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic              s1_valid_reg, s1_valid_next;
    out_word_t         s1_meta_reg, s1_meta;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;

    desc_t             head;
    logic              dq_empty, s1_adv, issue, is_byte, final_res;
    logic [IDX_W-1:0]  total;

    assign head      = dq_mem_reg[dq_rd_reg[DQ_AW-1:0]];
    assign dq_empty  = dq_wr_reg == dq_rd_reg;
    assign desc_full = (dq_wr_reg - dq_rd_reg) == (DQ_AW + 1)'(DQ_DEPTH);

    assign total     = IDX_W'(head.a_len) + IDX_W'(head.b_len);
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign issue     = !dq_empty && (!s1_valid_reg || s1_adv);
    assign is_byte   = idx_reg < total;
    assign final_res = is_byte ? ((idx_reg == total - IDX_W'(1)) && !head.err) : 1'b1;

    always_comb
    begin
        s1_meta.out_byte    = '0;
        s1_meta.chunk_start = is_byte &&
            (((idx_reg == '0) && head.a_fresh && (head.a_len != '0)) ||
             ((idx_reg == IDX_W'(head.a_len)) && head.b_fresh && (head.b_len != '0)));
        s1_meta.split_error = !is_byte;
        s1_meta.run_last    = final_res;
        s1_meta.message_end = final_res && head.msg_end;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (issue)
        begin
            idx_next = final_res ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // error words carry a zero byte
    always_comb
    begin
        out_word_next          = s1_meta_reg;
        out_word_next.out_byte = s1_meta_reg.split_error ? '0 : ram_rdata;
    end

    assign ram_re    = issue && is_byte;
    assign ram_raddr = rd_ptr_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_wr_reg     <= '0;
            dq_rd_reg     <= '0;
            idx_reg       <= '0;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (desc_push)
            begin
                dq_wr_reg <= dq_wr_reg + (DQ_AW + 1)'(1);
            end
            if (issue && final_res)
            begin
                dq_rd_reg <= dq_rd_reg + (DQ_AW + 1)'(1);
            end
            if (ram_re)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_push)
        begin
            dq_mem_reg[dq_wr_reg[DQ_AW-1:0]] <= desc;
        end
        if (issue)
        begin
            s1_meta_reg <= s1_meta;
        end
        if (s1_adv)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign rd_ptr    = rd_ptr_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: rtl/utf8_safe_chunker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_safe_chunker_unit: UTF-8 aware message chunker
// Cuts messages into chunks of at most max_chunk_len bytes, never splitting
// a character; oversize characters end the message with an error word.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            word
//  -------  ---  -------------------  ---------------------------------------
//  in       in   in_valid / in_stall  data_byte, msg_last
//  out      out  out_valid/out_stall  out_byte, chunk_start, message_end,
//                                     split_error, run_last
//  cfg      in   cfg_valid/cfg_ready  cfg_data = max_chunk_len (always ready)
//
//  - One input word is processed per cycle while in_stall is low; a word
//    yields 0 to HOLD_DEPTH+1 result words.
//  - The first result of a word passes the input register, the descriptor
//    queue, the byte queue read and the output register.
//  - in_stall rises when the byte queue (2**(clog2(HOLD_DEPTH)+1) bytes) or
//    the 4-entry descriptor queue is full; each drains as results are issued.
//  - Reset (rst_n, async low) empties both queues, clears the message state
//    and loads max_chunk_len = 256. No clearing pass is needed.
//  - A stalled output holds its word; the pipeline behind it holds too.
//
// Data path: bytes of the unit being collected are appended to a byte queue.
// When a unit completes, the step stage decides whether it opens a new chunk
// or overflows the limit and posts a descriptor; the sequencer then replays
// released bytes from the queue in order, tagging chunk starts, message end,
// errors and the last result of each input word. Bytes of a unit that fails
// are rolled back off the write side of the queue and never read.
// ----------------------------------------------------------------------------
module utf8_safe_chunker_unit #(
    parameter int HOLD_DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  u8sc_pkg::in_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output u8sc_pkg::out_word_t           out_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [u8sc_pkg::LIMIT_W-1:0]  cfg_data
);
    import u8sc_pkg::*;

    localparam int AW         = $clog2(HOLD_DEPTH) + 1;
    localparam int PW         = AW + 1;
    localparam int DATA_DEPTH = 1 << AW;

    // byte queue ports
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    // step -> sequencer
    logic              desc_push;
    desc_t             desc;

    // sequencer -> step
    logic              desc_full;
    logic [PW-1:0]     rd_ptr;

    u8sc_step #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rd_ptr    (rd_ptr),
        .desc_full (desc_full),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .desc_push (desc_push),
        .desc      (desc)
    );

    u8sc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_byte_q (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    u8sc_emit #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc_push (desc_push),
        .desc      (desc),
        .desc_full (desc_full),
        .rd_ptr    (rd_ptr),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
